// ===== rtl/mipd_pkg.sv =====
// Package for the masked indexed pixel decoder.
// Holds the controller states, command and status structs, and register and status codes.
// It depends on nothing else.
package mipd_pkg;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH       = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PALETTE_COUNT     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TRANSPARENT_RED   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TRANSPARENT_GREEN = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TRANSPARENT_BLUE  = 3'd4;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    localparam logic [1:0] STAT_OPAQUE      = 2'd0;
    localparam logic [1:0] STAT_TRANSPARENT = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND   = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic op_load;
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/mipd_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// It depends on nothing else.
module mipd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mipd_ctrl.sv =====
// Controller state machine of the masked indexed pixel decoder.
// Depends on mipd_pkg for the state type and the command and status structs.
module mipd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mipd_pkg::dp_status_t dp_status,
    output mipd_pkg::cmd_t      cmd
);
    import mipd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = dp_status.op_load ? S_IDLE : S_FINISH;
            end
            S_FINISH: begin
                if (dp_status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/mipd_dp.sv =====
// Datapath of the masked indexed pixel decoder: configuration registers, item registers,
// palette valid marks, palette store and output register.
// Depends on mipd_pkg and mipd_ram.
module mipd_dp #(
    parameter int PALETTE_DEPTH = 256,
    parameter int CHANNEL_BITS  = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  mipd_pkg::cmd_t                       cmd,
    output mipd_pkg::dp_status_t                 dp_status,
    input  logic                                 cfg_valid,
    input  logic [mipd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [mipd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                 s_op,
    input  logic [15:0]                          s_entry_color_number,
    input  logic [15:0]                          s_entry_red,
    input  logic [15:0]                          s_entry_green,
    input  logic [15:0]                          s_entry_blue,
    input  logic [15:0]                          s_pixel_x,
    input  logic [15:0]                          s_pixel_y,
    input  logic [7:0]                           s_mask_byte,
    input  logic [7:0]                           s_index_byte,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [15:0]                          m_out_red,
    output logic [15:0]                          m_out_green,
    output logic [15:0]                          m_out_blue,
    output logic [1:0]                           m_status
);
    import mipd_pkg::*;

    localparam int AW = $clog2(PALETTE_DEPTH);
    localparam int WORD_BITS = 3 * CHANNEL_BITS;

    function automatic logic [7:0] pick_index(input logic [8:0] count,
                                              input logic [7:0] ibyte,
                                              input logic [2:0] pos);
        logic [7:0] sel;
        if (count > 9'd16) begin
            sel = ibyte;
        end else if (count > 9'd4) begin
            sel = pos[0] ? {4'd0, ibyte[3:0]} : {4'd0, ibyte[7:4]};
        end else if (count > 9'd2) begin
            sel = {6'd0, ibyte[{~pos[1:0], 1'b1}], ibyte[{~pos[1:0], 1'b0}]};
        end else begin
            sel = {7'd0, ibyte[~pos]};
        end
        return sel;
    endfunction

    logic [15:0] image_width_reg;
    logic [8:0]  palette_count_reg;
    logic [7:0]  transp_red_reg;
    logic [7:0]  transp_green_reg;
    logic [7:0]  transp_blue_reg;

    logic                    op_reg;
    logic [15:0]             num_reg;
    logic [CHANNEL_BITS-1:0] red_reg;
    logic [CHANNEL_BITS-1:0] green_reg;
    logic [CHANNEL_BITS-1:0] blue_reg;
    logic [2:0]              x_low_reg;
    logic [2:0]              y_low_reg;
    logic [7:0]              mask_reg;
    logic [7:0]              ibyte_reg;

    logic [PALETTE_DEPTH-1:0] valid_reg;
    logic                     transp_reg;
    logic                     found_reg;

    logic        m_valid_reg;
    logic [15:0] out_red_reg;
    logic [15:0] out_green_reg;
    logic [15:0] out_blue_reg;
    logic [1:0]  status_reg;

    logic [2:0]           pos_low;
    logic [7:0]           idx;
    logic                 idx_in_range;
    logic                 num_in_range;
    logic                 load_we;
    logic                 lookup_re;
    logic [WORD_BITS-1:0] ram_rdata;

    assign pos_low      = 3'(y_low_reg * image_width_reg[2:0] + x_low_reg);
    assign idx          = pick_index(palette_count_reg, ibyte_reg, pos_low);
    assign idx_in_range = {1'b0, idx} < 9'(PALETTE_DEPTH);
    assign num_in_range = {1'b0, num_reg} < 17'(PALETTE_DEPTH);
    assign load_we      = cmd.exec && (op_reg == OP_LOAD) && num_in_range
                          && !valid_reg[num_reg[AW-1:0]];
    assign lookup_re    = cmd.exec && (op_reg == OP_PIXEL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg   <= 16'd32;
            palette_count_reg <= 9'd2;
            transp_red_reg    <= 8'd0;
            transp_green_reg  <= 8'd0;
            transp_blue_reg   <= 8'd0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:       image_width_reg   <= cfg_data;
                CFG_PALETTE_COUNT:     palette_count_reg <= cfg_data[8:0];
                CFG_TRANSPARENT_RED:   transp_red_reg    <= cfg_data[7:0];
                CFG_TRANSPARENT_GREEN: transp_green_reg  <= cfg_data[7:0];
                CFG_TRANSPARENT_BLUE:  transp_blue_reg   <= cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cfg_valid && (cfg_index == CFG_PALETTE_COUNT)) begin
            valid_reg <= '0;
        end else if (load_we) begin
            valid_reg[num_reg[AW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= s_op;
            num_reg   <= s_entry_color_number;
            red_reg   <= s_entry_red[CHANNEL_BITS-1:0];
            green_reg <= s_entry_green[CHANNEL_BITS-1:0];
            blue_reg  <= s_entry_blue[CHANNEL_BITS-1:0];
            x_low_reg <= s_pixel_x[2:0];
            y_low_reg <= s_pixel_y[2:0];
            mask_reg  <= s_mask_byte;
            ibyte_reg <= s_index_byte;
        end
        if (lookup_re) begin
            transp_reg <= !mask_reg[~x_low_reg];
            found_reg  <= idx_in_range && valid_reg[idx[AW-1:0]];
        end
    end

    mipd_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(PALETTE_DEPTH)
    ) u_palette (
        .aclk (aclk),
        .we   (load_we),
        .waddr(num_reg[AW-1:0]),
        .wdata({blue_reg, green_reg, red_reg}),
        .re   (lookup_re),
        .raddr(idx[AW-1:0]),
        .rdata(ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            if (transp_reg) begin
                out_red_reg   <= {8'd0, transp_red_reg};
                out_green_reg <= {8'd0, transp_green_reg};
                out_blue_reg  <= {8'd0, transp_blue_reg};
                status_reg    <= STAT_TRANSPARENT;
            end else if (found_reg) begin
                out_red_reg   <= 16'(ram_rdata[CHANNEL_BITS-1:0]);
                out_green_reg <= 16'(ram_rdata[2*CHANNEL_BITS-1:CHANNEL_BITS]);
                out_blue_reg  <= 16'(ram_rdata[3*CHANNEL_BITS-1:2*CHANNEL_BITS]);
                status_reg    <= STAT_OPAQUE;
            end else begin
                out_red_reg   <= 16'd0;
                out_green_reg <= 16'd0;
                out_blue_reg  <= 16'd0;
                status_reg    <= STAT_NOT_FOUND;
            end
        end
    end

    assign dp_status.op_load  = (op_reg == OP_LOAD);
    assign dp_status.out_free = !m_valid_reg || m_ready;

    assign m_valid     = m_valid_reg;
    assign m_out_red   = out_red_reg;
    assign m_out_green = out_green_reg;
    assign m_out_blue  = out_blue_reg;
    assign m_status    = status_reg;

endmodule

// ===== rtl/masked_indexed_pixel_decoder_unit.sv =====
// Channel   Handshake             Payload
// cfg       cfg_valid/cfg_ready   cfg_index, cfg_data
// s_        s_valid/s_ready       s_op, s_entry_*, s_pixel_x, s_pixel_y, s_mask_byte, s_index_byte
// m_        m_valid/m_ready       m_out_red, m_out_green, m_out_blue, m_status
//
// A load transfer passes through the controller's capture and execute steps, and a pixel
// transfer through capture, execute and finish around the registered read of the palette RAM.
// A finished pixel waits in the output register, and the next item is accepted meanwhile.
// A stalled result holds the finish step until the output register frees.
// Reset and any palette_count write clear all palette valid marks.
// Top level of the masked indexed pixel decoder; depends on mipd_pkg, mipd_ctrl and mipd_dp.
module masked_indexed_pixel_decoder_unit #(
    parameter int PALETTE_DEPTH = 256,
    parameter int CHANNEL_BITS  = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mipd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [mipd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_op,
    input  logic [15:0]                         s_entry_color_number,
    input  logic [15:0]                         s_entry_red,
    input  logic [15:0]                         s_entry_green,
    input  logic [15:0]                         s_entry_blue,
    input  logic [15:0]                         s_pixel_x,
    input  logic [15:0]                         s_pixel_y,
    input  logic [7:0]                          s_mask_byte,
    input  logic [7:0]                          s_index_byte,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [15:0]                         m_out_red,
    output logic [15:0]                         m_out_green,
    output logic [15:0]                         m_out_blue,
    output logic [1:0]                          m_status
);
    import mipd_pkg::*;

    cmd_t       cmd;
    dp_status_t dp_status;

    assign cfg_ready = 1'b1;

    mipd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .dp_status(dp_status),
        .cmd      (cmd)
    );

    mipd_dp #(
        .PALETTE_DEPTH(PALETTE_DEPTH),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .dp_status           (dp_status),
        .cfg_valid           (cfg_valid),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .s_op                (s_op),
        .s_entry_color_number(s_entry_color_number),
        .s_entry_red         (s_entry_red),
        .s_entry_green       (s_entry_green),
        .s_entry_blue        (s_entry_blue),
        .s_pixel_x           (s_pixel_x),
        .s_pixel_y           (s_pixel_y),
        .s_mask_byte         (s_mask_byte),
        .s_index_byte        (s_index_byte),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_out_red           (m_out_red),
        .m_out_green         (m_out_green),
        .m_out_blue          (m_out_blue),
        .m_status            (m_status)
    );

endmodule

// ===== dv/masked_indexed_pixel_decoder_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for masked_indexed_pixel_decoder_unit: directed and random
// palette loads and pixel decodes under varied idling, checked against a local predictor.
// Depends on mipd_pkg and the masked_indexed_pixel_decoder_unit RTL.
module masked_indexed_pixel_decoder_unit_tb;
    import mipd_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RX_HOLD_CYCLES = 300;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_LO = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic        op;
        logic [15:0] num;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  mask;
        logic [7:0]  ibyte;
    } pix_item_t;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [1:0]  status;
    } pix_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_op = 1'b0;
    logic [15:0] s_entry_color_number = '0;
    logic [15:0] s_entry_red = '0;
    logic [15:0] s_entry_green = '0;
    logic [15:0] s_entry_blue = '0;
    logic [15:0] s_pixel_x = '0;
    logic [15:0] s_pixel_y = '0;
    logic [7:0]  s_mask_byte = '0;
    logic [7:0]  s_index_byte = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_out_red;
    logic [15:0] m_out_green;
    logic [15:0] m_out_blue;
    logic [1:0]  m_status;

    masked_indexed_pixel_decoder_unit dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_op                 (s_op),
        .s_entry_color_number (s_entry_color_number),
        .s_entry_red          (s_entry_red),
        .s_entry_green        (s_entry_green),
        .s_entry_blue         (s_entry_blue),
        .s_pixel_x            (s_pixel_x),
        .s_pixel_y            (s_pixel_y),
        .s_mask_byte          (s_mask_byte),
        .s_index_byte         (s_index_byte),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_out_red            (m_out_red),
        .m_out_green          (m_out_green),
        .m_out_blue           (m_out_blue),
        .m_status             (m_status)
    );

    always #5 aclk = ~aclk;

    logic [15:0] img_width;
    logic [8:0]  pal_count;
    logic [7:0]  trans_red;
    logic [7:0]  trans_green;
    logic [7:0]  trans_blue;
    logic        pal_valid [0:255];
    logic [15:0] pal_red   [0:255];
    logic [15:0] pal_green [0:255];
    logic [15:0] pal_blue  [0:255];

    pix_item_t   pending_items[$];
    pix_result_t expected_pixels[$];
    pix_item_t   cur_item;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    int          hold_token = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          mismatches = 0;
    int          cycle_count = 0;

    function automatic void reset_palette_model();
        img_width   = 16'd32;
        pal_count   = 9'd2;
        trans_red   = 8'd0;
        trans_green = 8'd0;
        trans_blue  = 8'd0;
        for (int i = 0; i < 256; i++) begin
            pal_valid[i] = 1'b0;
        end
    endfunction

    function automatic void apply_reg(logic [CFG_INDEX_BITS-1:0] idx,
                                      logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            CFG_IMAGE_WIDTH: img_width = data;
            CFG_PALETTE_COUNT: begin
                pal_count = data[8:0];
                for (int i = 0; i < 256; i++) begin
                    pal_valid[i] = 1'b0;
                end
            end
            CFG_TRANSPARENT_RED: trans_red = data[7:0];
            CFG_TRANSPARENT_GREEN: trans_green = data[7:0];
            CFG_TRANSPARENT_BLUE: trans_blue = data[7:0];
            default: ;
        endcase
    endfunction

    function automatic void apply_item(pix_item_t it);
        pix_result_t res;
        logic [33:0] p;
        logic [2:0]  pos;
        logic [7:0]  idx;
        int          sh;
        if (it.op == OP_LOAD) begin
            if (it.num < 16'd256 && !pal_valid[it.num[7:0]]) begin
                pal_valid[it.num[7:0]] = 1'b1;
                pal_red[it.num[7:0]]   = it.red;
                pal_green[it.num[7:0]] = it.green;
                pal_blue[it.num[7:0]]  = it.blue;
            end
        end else begin
            p   = 34'(it.y) * 34'(img_width) + 34'(it.x);
            pos = p[2:0];
            sh  = 7 - int'(it.x[2:0]);
            if (it.mask[sh] == 1'b0) begin
                res.red    = {8'h00, trans_red};
                res.green  = {8'h00, trans_green};
                res.blue   = {8'h00, trans_blue};
                res.status = STAT_TRANSPARENT;
            end else begin
                if (pal_count > 9'd16) begin
                    idx = it.ibyte;
                end else if (pal_count > 9'd4) begin
                    idx = pos[0] ? {4'h0, it.ibyte[3:0]} : {4'h0, it.ibyte[7:4]};
                end else if (pal_count > 9'd2) begin
                    idx = (it.ibyte >> (6 - 2 * int'(pos[1:0]))) & 8'h03;
                end else begin
                    idx = (it.ibyte >> (7 - int'(pos))) & 8'h01;
                end
                if (pal_valid[idx]) begin
                    res.red    = pal_red[idx];
                    res.green  = pal_green[idx];
                    res.blue   = pal_blue[idx];
                    res.status = STAT_OPAQUE;
                end else begin
                    res.red    = 16'h0000;
                    res.green  = 16'h0000;
                    res.blue   = 16'h0000;
                    res.status = STAT_NOT_FOUND;
                end
            end
            expected_pixels.push_back(res);
        end
    endfunction

    function automatic pix_item_t load_item(logic [15:0] num, logic [15:0] r,
                                            logic [15:0] g, logic [15:0] b);
        pix_item_t it;
        it.op    = OP_LOAD;
        it.num   = num;
        it.red   = r;
        it.green = g;
        it.blue  = b;
        it.x     = 16'($urandom);
        it.y     = 16'($urandom);
        it.mask  = 8'($urandom);
        it.ibyte = 8'($urandom);
        return it;
    endfunction

    function automatic pix_item_t pixel_item(logic [15:0] x, logic [15:0] y,
                                             logic [7:0] m, logic [7:0] ib);
        pix_item_t it;
        it.op    = OP_PIXEL;
        it.num   = 16'($urandom);
        it.red   = 16'($urandom);
        it.green = 16'($urandom);
        it.blue  = 16'($urandom);
        it.x     = x;
        it.y     = y;
        it.mask  = m;
        it.ibyte = ib;
        return it;
    endfunction

    // The driver predicts each item at its transfer and then offers the next one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                apply_item(cur_item);
            end
            if (!s_valid || s_ready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    cur_item = pending_items.pop_front();
                    s_op                 <= cur_item.op;
                    s_entry_color_number <= cur_item.num;
                    s_entry_red          <= cur_item.red;
                    s_entry_green        <= cur_item.green;
                    s_entry_blue         <= cur_item.blue;
                    s_pixel_x            <= cur_item.x;
                    s_pixel_y            <= cur_item.y;
                    s_mask_byte          <= cur_item.mask;
                    s_index_byte         <= cur_item.ibyte;
                    s_valid              <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        pix_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("Unexpected result: red %h green %h blue %h status %0d",
                                 m_out_red, m_out_green, m_out_blue, m_status);
                    end
                    mismatches++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_out_red !== want.red || m_out_green !== want.green ||
                        m_out_blue !== want.blue || m_status !== want.status) begin
                        if (mismatches < 10) begin
                            $display("Mismatch: expected %h %h %h st %0d, got %h %h %h st %0d",
                                     want.red, want.green, want.blue, want.status,
                                     m_out_red, m_out_green, m_out_blue, m_status);
                        end
                        mismatches++;
                    end
                end
            end
            if (hold_seen != hold_token) begin
                hold_seen <= hold_token;
                hold_left <= RX_HOLD_CYCLES;
                m_ready   <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_items.size() != 0 || s_valid || expected_pixels.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        apply_reg(idx, data);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(int width, int count, int tr, int tg, int tb, int tx_pct,
                             int rx_pct, int n_pixels, bit hold);
        logic [15:0] loaded[$];
        logic [15:0] num;
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  m;
        logic [7:0]  ib;
        int          n_loads;
        wait_drained();
        write_reg(CFG_IMAGE_WIDTH, 16'(width));
        write_reg(CFG_PALETTE_COUNT, 16'(count));
        write_reg(CFG_TRANSPARENT_RED, 16'(tr));
        write_reg(CFG_TRANSPARENT_GREEN, 16'(tg));
        write_reg(CFG_TRANSPARENT_BLUE, 16'(tb));
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        if (hold) begin
            hold_token++;
        end
        n_loads = (count < 24) ? count + 2 : 40;
        for (int i = 0; i < n_loads; i++) begin
            num = 16'($urandom_range(count - 1));
            loaded.push_back(num);
            pending_items.push_back(load_item(num, 16'($urandom), 16'($urandom),
                                              16'($urandom)));
        end
        pending_items.push_back(load_item(16'($urandom_range(65535, 256)), 16'($urandom),
                                          16'($urandom), 16'($urandom)));
        for (int i = 0; i < n_pixels; i++) begin
            if ($urandom_range(99) < 8) begin
                pending_items.push_back(load_item(16'($urandom_range(255)), 16'($urandom),
                                                  16'($urandom), 16'($urandom)));
            end
            x  = ($urandom_range(99) < 85) ? 16'($urandom_range(width - 1))
                                           : 16'($urandom_range(65535));
            y  = ($urandom_range(3) == 0) ? 16'($urandom_range(65535))
                                          : 16'($urandom_range(15));
            m  = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                          : (8'($urandom_range(255)) | (8'h80 >> x[2:0]));
            ib = 8'($urandom_range(255));
            if (count > 16 && $urandom_range(1) == 1) begin
                ib = loaded[$urandom_range(loaded.size() - 1)][7:0];
            end
            pending_items.push_back(pixel_item(x, y, m, ib));
        end
    endtask

    initial begin
        reset_palette_model();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        pending_items.push_back(pixel_item(16'd0, 16'd0, 8'h80, 8'h00));
        pending_items.push_back(pixel_item(16'd1, 16'd0, 8'h00, 8'hFF));
        pending_items.push_back(load_item(16'd0, 16'hFFFF, 16'h0000, 16'hFFFF));
        pending_items.push_back(load_item(16'd1, 16'h0000, 16'hFFFF, 16'h1234));
        pending_items.push_back(load_item(16'd0, 16'h1111, 16'h2222, 16'h3333));
        pending_items.push_back(load_item(16'd256, 16'h4444, 16'h5555, 16'h6666));
        pending_items.push_back(load_item(16'hFFFF, 16'h7777, 16'h8888, 16'h9999));
        pending_items.push_back(pixel_item(16'd0, 16'd0, 8'h80, 8'h00));
        pending_items.push_back(pixel_item(16'd7, 16'd0, 8'h01, 8'h01));
        pending_items.push_back(pixel_item(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF));
        pending_items.push_back(pixel_item(16'd100, 16'd0, 8'hFF, 8'h55));
        pending_items.push_back(pixel_item(16'd3, 16'd2, 8'h00, 8'h00));
        wait_drained();
        write_reg(CFG_TRANSPARENT_RED, 16'h00FF);
        write_reg(CFG_TRANSPARENT_GREEN, 16'h00FF);
        write_reg(CFG_TRANSPARENT_BLUE, 16'h00FF);
        write_reg(CFG_IMAGE_WIDTH, 16'd1);
        write_reg(CFG_PALETTE_COUNT, 16'd5);
        write_reg(CFG_UNUSED_LO, 16'hFFFF);
        write_reg(CFG_UNUSED_HI, 16'h0000);
        pending_items.push_back(pixel_item(16'd0, 16'd0, 8'h00, 8'h00));
        pending_items.push_back(pixel_item(16'd0, 16'd0, 8'h80, 8'hC0));
        pending_items.push_back(load_item(16'd12, 16'hABCD, 16'h0000, 16'hFFFF));
        pending_items.push_back(pixel_item(16'd0, 16'd0, 8'h80, 8'hC0));
        pending_items.push_back(pixel_item(16'd1, 16'd0, 8'h40, 8'h0C));
        wait_drained();
        write_reg(CFG_PALETTE_COUNT, 16'd256);
        write_reg(CFG_IMAGE_WIDTH, 16'hFFFF);
        pending_items.push_back(load_item(16'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        pending_items.push_back(pixel_item(16'd0, 16'd0, 8'hFF, 8'hFF));
        pending_items.push_back(pixel_item(16'd2, 16'd0, 8'h20, 8'hFE));

        run_phase(32, 2, 0, 0, 0, 0, 0, 60, 1'b0);
        run_phase(1, 1, 255, 255, 255, 46, 0, 60, 1'b0);
        run_phase(65535, 4, $urandom_range(255), $urandom_range(255), $urandom_range(255),
                  0, 46, 60, 1'b0);
        run_phase($urandom_range(65535, 1), 3, $urandom_range(255), $urandom_range(255),
                  $urandom_range(255), 35, 35, 60, 1'b0);
        run_phase(7, 16, $urandom_range(255), $urandom_range(255), $urandom_range(255),
                  0, 0, 60, 1'b0);
        run_phase($urandom_range(65535, 1), 5, $urandom_range(255), $urandom_range(255),
                  $urandom_range(255), 46, 0, 60, 1'b0);
        run_phase(3, 17, 0, 0, 0, 0, 46, 60, 1'b0);
        run_phase($urandom_range(65535, 1), 256, 255, 255, 255, 35, 35, 60, 1'b0);
        run_phase($urandom_range(40, 1), $urandom_range(256, 1), $urandom_range(255),
                  $urandom_range(255), $urandom_range(255), 0, 0, 50, 1'b1);
        run_phase($urandom_range(65535, 1), $urandom_range(256, 1), $urandom_range(255),
                  $urandom_range(255), $urandom_range(255), 35, 35, 60, 1'b0);

        wait_drained();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/mipd_pkg.sv
rtl/mipd_ram.sv
rtl/mipd_ctrl.sv
rtl/mipd_dp.sv
rtl/masked_indexed_pixel_decoder_unit.sv
dv/masked_indexed_pixel_decoder_unit_tb.sv
